// ===== rtl/spti_pkg.sv =====
// Package: shared types, constants and codes for the point table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package spti_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_INTERP = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [2:0] TR_EMPTY   = 3'd0;
    localparam logic [2:0] TR_CONST   = 3'd1;
    localparam logic [2:0] TR_RISING  = 3'd2;
    localparam logic [2:0] TR_FALLING = 3'd3;
    localparam logic [2:0] TR_MIXED   = 3'd4;

    typedef struct packed {
        logic               command;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
    } in_word_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [15:0] result_y;
        logic        [4:0]  point_count;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
        logic        [2:0]  trend;
    } out_word_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [32:0] num;
        logic [16:0] den;
    } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_point_table_interpolator_top.sv =====
// Top level: sorted point table with piecewise linear interpolation.
`timescale 1ns / 1ps
`default_nettype none
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_ready  | spti_pkg::in_word_t (command, x, y)
//  out     | output    | out_valid/out_ready| spti_pkg::out_word_t (status..trend)
//
// One word at a time. Timing is set by the single-port point RAMs and the divider: search
// reads the RAM once per halving, a shift reads and rewrites each moved entry, and the
// statistics scan reads each stored y and then loads the output; interpolate adds the
// segment reads and the divide. Reset clears the point count, the state and the output
// valid flag; RAM contents are undefined and never used beyond the count. A finished word
// sits in the output register while out_ready is low; a new input word is taken once that
// register is empty.
module sorted_point_table_interpolator_top #(
    parameter int DEPTH = spti_pkg::DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire spti_pkg::in_word_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output spti_pkg::out_word_t       out_data
);
    import spti_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SRCH   = 12'b000000000010, // issue read at mid
        S_SRCHW  = 12'b000000000100, // compare returned x
        S_SHRD   = 12'b000000001000, // read entry i-1
        S_SHWR   = 12'b000000010000, // write it to i
        S_PUT    = 12'b000000100000,
        S_SEGRD  = 12'b000001000000, // read lower end of segment
        S_SEGRD2 = 12'b000010000000, // read upper end
        S_SEGW   = 12'b000100000000,
        S_DIV    = 12'b001000000000,
        S_STAT   = 12'b010000000000, // scan y for min/max/trend
        S_DONE   = 12'b100000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          cmd_reg;
    logic signed [15:0] x_reg, y_reg;
    logic          dup_reg, dup_next;
    logic [1:0]    status_reg, status_next;
    logic signed [15:0] res_reg, res_next;
    logic signed [15:0] x0_reg, x0_next, y0_reg, y0_next;
    logic          ph_reg, ph_next;
    logic signed [15:0] mn_reg, mn_next, mx_reg, mx_next, py_reg, py_next;
    logic          up_reg, up_next, dn_reg, dn_next;
    logic          ov_reg, ov_next;
    out_word_t     ow_reg, ow_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [15:0]   xw, yw, xr, yr;
    logic [CW-1:0] mid;
    div_req_t      dreq;
    logic          ddone;
    logic signed [33:0] quot;
    logic signed [16:0] dy, dx_s, den_s;
    logic signed [33:0] prod;
    logic signed [34:0] sum;

    spti_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_xram
        (.clk(clk), .we(we), .addr(addr), .wdata(xw), .rdata(xr));
    spti_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_yram
        (.clk(clk), .we(we), .addr(addr), .wdata(yw), .rdata(yr));
    spti_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(quot));

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = ow_reg;

    // segment arithmetic from registered end points (x1,y1 straight from RAM)
    assign dy    = $signed({yr[15], yr}) - $signed({y0_reg[15], y0_reg});
    assign dx_s  = $signed({x_reg[15], x_reg}) - $signed({x0_reg[15], x0_reg});
    assign den_s = $signed({xr[15], xr}) - $signed({x0_reg[15], x0_reg});
    assign prod  = dy * dx_s;
    assign sum   = $signed({{19{y0_reg[15]}}, y0_reg}) + $signed({quot[33], quot});

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; lo_next = lo_reg; hi_next = hi_reg; idx_next = idx_reg;
        dup_next = dup_reg; status_next = status_reg; res_next = res_reg;
        x0_next = x0_reg; y0_next = y0_reg; ph_next = ph_reg;
        mn_next = mn_reg; mx_next = mx_reg; py_next = py_reg;
        up_next = up_reg; dn_next = dn_reg; ov_next = ov_reg; ow_next = ow_reg;
        we = 1'b0; addr = '0; xw = x_reg; yw = y_reg;
        dreq = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    lo_next = '0; hi_next = cnt_reg; dup_next = 1'b0;
                    status_next = ST_OK; res_next = '0;
                    if (in_data.command == CMD_INSERT)
                    begin
                        if (cnt_reg >= CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next = S_STAT;
                        end
                        else
                        begin
                            state_next = S_SRCH;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                    idx_next = '0; ph_next = 1'b0;
                end
            end
            S_SRCH:
            begin
                addr = mid[AW-1:0];
                if (lo_reg < hi_reg)
                begin
                    state_next = S_SRCHW;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    if (dup_reg)
                    begin
                        status_next = ST_DUP;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        idx_next = cnt_reg;
                        state_next = (cnt_reg > lo_reg) ? S_SHRD : S_PUT;
                    end
                end
                else
                begin
                    // lo = count of x <= query; clamp to [1, count-1], or 0 for a single point
                    if (cnt_reg == CW'(1))
                    begin
                        idx_next = '0;
                    end
                    else if (lo_reg == '0)
                    begin
                        idx_next = CW'(1);
                    end
                    else if (lo_reg > cnt_reg - CW'(1))
                    begin
                        idx_next = cnt_reg - CW'(1);
                    end
                    else
                    begin
                        idx_next = lo_reg;
                    end
                    state_next = S_SEGRD;
                end
            end
            S_SRCHW:
            begin
                addr = mid[AW-1:0];
                if ($signed(xr) == x_reg)
                begin
                    dup_next = 1'b1;
                end
                if ($signed(xr) <= x_reg)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end
            S_SHRD:
            begin
                addr = AW'(idx_reg - CW'(1));
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                we = 1'b1; addr = idx_reg[AW-1:0]; xw = xr; yw = yr;
                idx_next = idx_reg - CW'(1);
                state_next = (idx_reg - CW'(1) > lo_reg) ? S_SHRD : S_PUT;
            end
            S_PUT:
            begin
                we = 1'b1; addr = lo_reg[AW-1:0];
                cnt_next = cnt_reg + CW'(1);
                state_next = S_STAT;
                idx_next = '0;
            end
            S_SEGRD:
            begin
                addr = (cnt_reg == CW'(1)) ? '0 : AW'(idx_reg - CW'(1));
                state_next = S_SEGRD2;
            end
            S_SEGRD2:
            begin
                addr = idx_reg[AW-1:0];
                x0_next = xr; y0_next = yr;
                if (cnt_reg == CW'(1))
                begin
                    res_next = yr;
                    idx_next = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = S_SEGW;
                end
            end
            S_SEGW:
            begin
                addr = idx_reg[AW-1:0];
                dreq.start = 1'b1;
                dreq.neg   = prod[33] ^ den_s[16];
                dreq.num   = prod[33] ? 33'(-prod) : prod[32:0];
                dreq.den   = den_s[16] ? 17'(-den_s) : den_s;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (ddone)
                begin
                    if (sum > 35'sd32767)
                    begin
                        res_next = 16'sh7fff;
                    end
                    else if (sum < -35'sd32768)
                    begin
                        res_next = -16'sh8000;
                    end
                    else
                    begin
                        res_next = sum[15:0];
                    end
                    idx_next = '0;
                    state_next = S_STAT;
                end
            end
            S_STAT:
            begin
                // ph 0: read idx; ph 1: fold returned y
                addr = idx_reg[AW-1:0];
                if (!ph_reg)
                begin
                    if (idx_reg >= cnt_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ph_next = 1'b1;
                    end
                end
                else
                begin
                    ph_next = 1'b0;
                    idx_next = idx_reg + CW'(1);
                    py_next = yr;
                    if (idx_reg == '0)
                    begin
                        mn_next = yr; mx_next = yr; up_next = 1'b0; dn_next = 1'b0;
                    end
                    else
                    begin
                        if ($signed(yr) < mn_reg) mn_next = yr;
                        if ($signed(yr) > mx_reg) mx_next = yr;
                        if (py_reg < $signed(yr)) up_next = 1'b1;
                        else if (py_reg > $signed(yr)) dn_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ow_next.status = status_reg;
                    ow_next.result_y = res_reg;
                    ow_next.point_count = 5'(cnt_reg);
                    ow_next.min_y = (cnt_reg == '0) ? '0 : mn_reg;
                    ow_next.max_y = (cnt_reg == '0) ? '0 : mx_reg;
                    if (cnt_reg == '0) ow_next.trend = TR_EMPTY;
                    else if (up_reg && dn_reg) ow_next.trend = TR_MIXED;
                    else if (up_reg) ow_next.trend = TR_RISING;
                    else if (dn_reg) ow_next.trend = TR_FALLING;
                    else ow_next.trend = TR_CONST;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_data.command;
            x_reg   <= in_data.x_value;
            y_reg   <= in_data.y_value;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; idx_reg <= idx_next;
        dup_reg <= dup_next; status_reg <= status_next; res_reg <= res_next;
        x0_reg <= x0_next; y0_reg <= y0_next; ph_reg <= ph_next;
        mn_reg <= mn_next; mx_reg <= mx_next; py_reg <= py_next;
        up_reg <= up_next; dn_reg <= dn_next; ow_reg <= ow_next;
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("point count beyond depth");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |-> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("point count moved by other than one");
    a_write_ins: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> cmd_reg == CMD_INSERT) else $error("table written on interpolate");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
endmodule
`default_nettype wire

// ===== rtl/spti_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module spti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/spti_div.sv =====
// Restoring divider: unsigned 33/17 bit quotient, one bit per cycle, sign applied at end.
`timescale 1ns / 1ps
`default_nettype none
module spti_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire spti_pkg::div_req_t        req,
    output logic                           done,
    output logic signed [33:0]             quot
);
    import spti_pkg::*;

    logic [32:0] q_reg, q_next;
    logic [17:0] r_reg, r_next;
    logic [16:0] d_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_next;
    logic [17:0] shifted;
    logic [17:0] diff;

    always_comb
    begin
        shifted   = {r_reg[16:0], q_reg[32]};
        diff      = shifted - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = req.num;
            r_next    = '0;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                r_next = diff;
                q_next = {q_reg[31:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (req.start)
        begin
            d_reg   <= req.den;
            neg_reg <= req.neg;
        end
    end

    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule
`default_nettype wire

// ===== tb/tb_sorted_point_table_interpolator_top.sv =====
// Testbench for the sorted point table interpolator: random and directed words, scoreboarded.
`timescale 1ns / 1ps
module tb_sorted_point_table_interpolator_top;
    import spti_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sorted_point_table_interpolator_top #(.DEPTH(TABLE_DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the point table, kept sorted by x.
    int        tbl_x [TABLE_DEPTH];
    int        tbl_y [TABLE_DEPTH];
    int        tbl_count;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        mismatches;
    int        cycle_count;
    bit        stimulus_done;

    // Works out the result word for one accepted input word and updates the shadow table.
    function automatic out_word_t table_apply(input in_word_t w);
        out_word_t r;
        int        x;
        int        y;
        int        i;
        int        k;
        bit        found;
        bit        up;
        bit        down;
        longint    num;
        longint    den;
        longint    v;
        x = int'(w.x_value);
        y = int'(w.y_value);
        r = '0;
        r.status = ST_OK;
        if (w.command == CMD_INSERT)
        begin
            found = 1'b0;
            for (i = 0; i < tbl_count; i++)
                if (tbl_x[i] == x)
                    found = 1'b1;
            if (tbl_count >= TABLE_DEPTH)
                r.status = ST_FULL;
            else if (found)
                r.status = ST_DUP;
            else
            begin
                i = tbl_count;
                while (i > 0 && tbl_x[i-1] > x)
                begin
                    tbl_x[i] = tbl_x[i-1];
                    tbl_y[i] = tbl_y[i-1];
                    i--;
                end
                tbl_x[i] = x;
                tbl_y[i] = y;
                tbl_count++;
            end
        end
        else if (tbl_count == 0)
            r.status = ST_EMPTY;
        else if (tbl_count == 1)
            r.result_y = 16'(tbl_y[0]);
        else
        begin
            // segment: number of stored x at or below x, clamped to the inner range
            k = 0;
            for (i = 0; i < tbl_count; i++)
                if (tbl_x[i] <= x)
                    k++;
            if (k < 1)
                k = 1;
            if (k > tbl_count - 1)
                k = tbl_count - 1;
            num = longint'(tbl_y[k] - tbl_y[k-1]) * longint'(x - tbl_x[k-1]);
            den = longint'(tbl_x[k] - tbl_x[k-1]);
            v = longint'(tbl_y[k-1]) + num / den;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            r.result_y = 16'(v);
        end
        r.point_count = 5'(tbl_count);
        if (tbl_count > 0)
        begin
            r.min_y = 16'(tbl_y[0]);
            r.max_y = 16'(tbl_y[0]);
            for (i = 1; i < tbl_count; i++)
            begin
                if ($signed(16'(tbl_y[i])) < r.min_y)
                    r.min_y = 16'(tbl_y[i]);
                if ($signed(16'(tbl_y[i])) > r.max_y)
                    r.max_y = 16'(tbl_y[i]);
            end
        end
        up = 1'b0;
        down = 1'b0;
        for (i = 1; i < tbl_count; i++)
        begin
            if (tbl_y[i-1] < tbl_y[i])
                up = 1'b1;
            else if (tbl_y[i-1] > tbl_y[i])
                down = 1'b1;
        end
        if (tbl_count == 0)
            r.trend = TR_EMPTY;
        else if (up && down)
            r.trend = TR_MIXED;
        else if (up)
            r.trend = TR_RISING;
        else if (down)
            r.trend = TR_FALLING;
        else
            r.trend = TR_CONST;
        return r;
    endfunction

    function automatic in_word_t make_word(input logic cmd, input int x, input int y);
        in_word_t w;
        w.command = cmd;
        w.x_value = 16'(x);
        w.y_value = 16'(y);
        return w;
    endfunction

    function automatic int rand16();
        return int'($signed(16'($urandom)));
    endfunction

    // Random x, often near a small window so duplicates and in-table queries occur.
    function automatic int rand_x();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 40) - 20;
        else if (sel == 4)
            return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        return rand16();
    endfunction

    // Stimulus: directed words, then one random phase that fills and queries the table, then
    // a burst of inserts. The table is never cleared: once it fills it stays full, and
    // interpolation keeps exercising it with fresh queries.
    initial
    begin
        int n;
        int i;
        int fill;
        // directed: empty table, extremes, duplicate, one point
        pending_words.push_back(make_word(CMD_INTERP, 0, 0));
        pending_words.push_back(make_word(CMD_INTERP, -32768, 32767));
        pending_words.push_back(make_word(CMD_INSERT, 100, -32768));
        pending_words.push_back(make_word(CMD_INTERP, 32767, 0));
        pending_words.push_back(make_word(CMD_INSERT, 100, 5));
        pending_words.push_back(make_word(CMD_INSERT, -32768, 32767));
        pending_words.push_back(make_word(CMD_INTERP, 32767, -1));
        pending_words.push_back(make_word(CMD_INTERP, -32768, 0));
        pending_words.push_back(make_word(CMD_INTERP, 100, 0));
        pending_words.push_back(make_word(CMD_INSERT, 32767, 32767));
        pending_words.push_back(make_word(CMD_INTERP, 32767, 0));
        pending_words.push_back(make_word(CMD_INTERP, 200, 0));
        pending_words.push_back(make_word(CMD_INSERT, 101, 32767));
        pending_words.push_back(make_word(CMD_INTERP, 102, 0));
        pending_words.push_back(make_word(CMD_INTERP, 99, 0));
        pending_words.push_back(make_word(CMD_INTERP, 100, 0));
        n = 16;
        // random first fill with in-between queries
        fill = 4;
        while (n < 1340)
        begin
            if (fill < TABLE_DEPTH + 2 && $urandom_range(0, 2) != 0)
            begin
                pending_words.push_back(make_word(CMD_INSERT, rand_x(), rand16()));
                fill++;
            end
            else
                pending_words.push_back(make_word($urandom_range(0, 9) == 0 ? CMD_INSERT
                                                                          : CMD_INTERP,
                                                  rand_x(), rand16()));
            n++;
        end
        for (i = 0; i < 10; i++)
            pending_words.push_back(make_word(CMD_INSERT, rand16(), rand16()));
        stimulus_done = 1'b1;
    end

    // Driver: random gap before each word, valid held until accepted.
    int in_gap;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_words.push_back(table_apply(in_data));
                void'(pending_words.pop_front());
                in_gap = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0)
                    in_gap = 0;
                if (in_gap == 0 && pending_words.size() > 0)
                    in_data <= pending_words[0];
                else
                    in_valid <= 1'b0;
            end
            else if (!in_valid && pending_words.size() > 0)
            begin
                if (in_gap > 0)
                    in_gap--;
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_words[0];
                end
            end
        end
    end

    // Monitor: random stall per word on out_ready, compare against the oldest expectation.
    int out_stall;
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", out_data);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.status !== want.status || out_data.result_y !== want.result_y
                        || out_data.point_count !== want.point_count
                        || out_data.min_y !== want.min_y || out_data.max_y !== want.max_y
                        || out_data.trend !== want.trend)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected st=%0d y=%0d n=%0d min=%0d max=%0d tr=%0d",
                                     want.status, want.result_y, want.point_count,
                                     want.min_y, want.max_y, want.trend);
                            $display("          got      st=%0d y=%0d n=%0d min=%0d max=%0d tr=%0d",
                                     out_data.status, out_data.result_y, out_data.point_count,
                                     out_data.min_y, out_data.max_y, out_data.trend);
                        end
                    end
                end
                out_stall = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0)
                    out_stall = 0;
                out_ready <= (out_stall == 0);
            end
            else if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= (out_stall == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Reset, then wait for the queues to drain and a settling margin, with a cycle limit.
    initial
    begin
        int settle;
        mismatches = 0;
        cycle_count = 0;
        in_gap = 0;
        out_stall = 0;
        settle = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (settle < 200 && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
            if (stimulus_done && pending_words.size() == 0 && !in_valid
                && expected_words.size() == 0)
                settle++;
            else
                settle = 0;
        end
        if (cycle_count >= CYCLE_LIMIT)
            $display("Testbench completed WITH ERRORS");
        else if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
